// ===== sv/occupancy_grid_ray_update_defines.svh =====
// Assertion macros shared by the occupancy grid checker.
`ifndef OCCUPANCY_GRID_RAY_UPDATE_DEFINES_SVH
`define OCCUPANCY_GRID_RAY_UPDATE_DEFINES_SVH

// Check cons in the same cycle as ante.
`define OGRU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define OGRU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ogru_pkg.sv =====
// Types, constants and codes of the occupancy grid ray update block.
package ogru_pkg;

  localparam int CoordW      = 10;
  localparam int LevelW      = 6;
  localparam int ClassW      = 2;
  localparam int ErrW        = 13;
  localparam int CfgIdxW     = 3;
  localparam int CfgDataW    = 6;
  localparam int GridSizeDef = 1024;

  localparam logic [CfgIdxW-1:0] CFG_HIT_STEP    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_MISS_STEP   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_LEVEL_LIMIT = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_OCC_THR     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_FREE_THR    = 3'd4;

  localparam logic OP_TRACE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef enum logic [ClassW-1:0] {
    CLASS_OCCUPIED = 2'd0,
    CLASS_FREE     = 2'd1,
    CLASS_UNKNOWN  = 2'd2
  } cell_class_e;

  typedef struct packed {
    logic              operation;
    logic [CoordW-1:0] start_x;
    logic [CoordW-1:0] start_y;
    logic [CoordW-1:0] target_x;
    logic [CoordW-1:0] target_y;
    logic              hit;
  } in_word_t;

  typedef struct packed {
    logic signed [LevelW-1:0] cell_level;
    logic [ClassW-1:0]        cell_class;
  } out_word_t;

  typedef struct packed {
    logic [3:0]               hit_step;
    logic [3:0]               miss_step;
    logic [4:0]               level_limit;
    logic signed [LevelW-1:0] occ_thr;
    logic signed [LevelW-1:0] free_thr;
  } cfg_t;

  typedef struct packed {
    logic              is_read;
    logic [CoordW-1:0] x0;
    logic [CoordW-1:0] y0;
    logic [CoordW-1:0] x1;
    logic [CoordW-1:0] y1;
    logic              hit;
    logic [CoordW-1:0] dx;
    logic [CoordW-1:0] dy;
    logic              x_neg;
    logic              y_neg;
  } cmd_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_stat_t;

endpackage

// ===== sv/ogru_ram.sv =====
// Generic single write, single read RAM with registered read data.
module ogru_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/ogru_front.sv =====
// Front end: accepts words, classifies them into commands and queues them.
module ogru_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  ogru_pkg::in_word_t in_word_i,
  input  ogru_pkg::back_stat_t stat_i,
  output logic              cmd_valid_o,
  output ogru_pkg::cmd_t    cmd_o
);
  import ogru_pkg::*;

  cmd_t       ent_q [2];
  logic       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       acc, pop_en;
  cmd_t       cmd_new;

  always_comb begin
    cmd_new.is_read = (in_word_i.operation == OP_READ);
    cmd_new.x0      = in_word_i.start_x;
    cmd_new.y0      = in_word_i.start_y;
    cmd_new.x1      = in_word_i.target_x;
    cmd_new.y1      = in_word_i.target_y;
    cmd_new.hit     = in_word_i.hit;
    cmd_new.x_neg   = !(in_word_i.start_x < in_word_i.target_x);
    cmd_new.y_neg   = !(in_word_i.start_y < in_word_i.target_y);
    cmd_new.dx      = cmd_new.x_neg ? in_word_i.start_x - in_word_i.target_x
                                    : in_word_i.target_x - in_word_i.start_x;
    cmd_new.dy      = cmd_new.y_neg ? in_word_i.start_y - in_word_i.target_y
                                    : in_word_i.target_y - in_word_i.start_y;
  end

  assign full        = (cnt_q == 2'd2) || stat_i.clearing;
  assign acc         = push && !full;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = ent_q[rptr_q];
  assign pop_en      = stat_i.pop && cmd_valid_o;

  always_comb begin
    wptr_d = wptr_q ^ acc;
    rptr_d = rptr_q ^ pop_en;
    cnt_d  = cnt_q + {1'b0, acc} - {1'b0, pop_en};
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      ent_q[wptr_q] <= cmd_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ===== sv/ogru_back.sv =====
// Back end: clears the grid, walks rays with read-modify-write and returns results.
module ogru_back #(
  parameter int GridSize = ogru_pkg::GridSizeDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ogru_pkg::cfg_t       cfg_i,
  input  logic                 cmd_valid_i,
  input  ogru_pkg::cmd_t       cmd_i,
  output ogru_pkg::back_stat_t stat_o,
  output logic                 empty,
  input  logic                 pop,
  output ogru_pkg::out_word_t  out_word_o
);
  import ogru_pkg::*;

  localparam int Depth = GridSize * GridSize;
  localparam int AW    = $clog2(Depth);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_WR    = 3'd3;
  localparam logic [2:0] S_RES   = 3'd4;
  localparam logic [2:0] S_RES2  = 3'd5;

  logic [2:0]            state_q, state_d;
  logic [AW-1:0]         clr_q, clr_d;
  logic [CoordW-1:0]     x_q, x_d, y_q, y_d;
  logic signed [ErrW-1:0] err_q, err_d;
  cmd_t                  cmd_q, cmd_d;
  logic                  out_valid_q, out_valid_d;
  out_word_t             out_q, out_d;

  logic                  we;
  logic [AW-1:0]         waddr, raddr, cur_addr, tgt_addr;
  logic [LevelW-1:0]     wdata, rdata;
  logic                  cur_in, tgt_in, is_end, pop_cmd;
  logic signed [7:0]     delta, sum, lim, lvl_c;
  logic signed [ErrW:0]  twice, dxs, dys;
  logic signed [ErrW-1:0] dx_e, dy_e;
  logic signed [LevelW-1:0] lvl_r;

  assign cur_in   = (32'(x_q) < GridSize) && (32'(y_q) < GridSize);
  assign tgt_in   = (32'(cmd_q.x1) < GridSize) && (32'(cmd_q.y1) < GridSize);
  assign cur_addr = AW'(32'(y_q) * 32'(GridSize) + 32'(x_q));
  assign tgt_addr = AW'(32'(cmd_q.y1) * 32'(GridSize) + 32'(cmd_q.x1));
  assign is_end   = (x_q == cmd_q.x1) && (y_q == cmd_q.y1);
  assign raddr    = ((state_q == S_RES) || (state_q == S_RES2)) ? tgt_addr : cur_addr;

  always_comb begin
    delta = (is_end && cmd_q.hit) ? $signed({4'b0, cfg_i.hit_step})
                                  : -$signed({4'b0, cfg_i.miss_step});
    sum   = 8'(signed'(rdata)) + delta;
    lim   = $signed({3'b0, cfg_i.level_limit});
    if (sum > lim) begin
      lvl_c = lim;
    end else if (sum < -lim) begin
      lvl_c = -lim;
    end else begin
      lvl_c = sum;
    end
    dx_e  = $signed({3'b0, cmd_q.dx});
    dy_e  = -$signed({3'b0, cmd_q.dy});
    dxs   = (ErrW+1)'(dx_e);
    dys   = (ErrW+1)'(dy_e);
    twice = {err_q, 1'b0};
    lvl_r = tgt_in ? signed'(rdata) : '0;
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    x_d         = x_q;
    y_d         = y_q;
    err_d       = err_q;
    cmd_d       = cmd_q;
    out_valid_d = out_valid_q && !pop;
    out_d       = out_q;
    we          = 1'b0;
    waddr       = cur_addr;
    wdata       = lvl_c[LevelW-1:0];
    pop_cmd     = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = clr_q + 1'b1;
        if (32'(clr_q) == Depth - 1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid_i) begin
          pop_cmd = 1'b1;
          cmd_d   = cmd_i;
          x_d     = cmd_i.x0;
          y_d     = cmd_i.y0;
          err_d   = $signed({3'b0, cmd_i.dx}) - $signed({3'b0, cmd_i.dy});
          state_d = cmd_i.is_read ? S_RES : S_RD;
        end
      end
      S_RD: begin
        state_d = S_WR;
      end
      S_WR: begin
        we = cur_in;
        if (is_end) begin
          state_d = S_RES;
        end else begin
          state_d = S_RD;
          err_d   = err_q + ((twice >= dys) ? dy_e : '0) + ((twice <= dxs) ? dx_e : '0);
          if (twice >= dys) begin
            x_d = cmd_q.x_neg ? x_q - 1'b1 : x_q + 1'b1;
          end
          if (twice <= dxs) begin
            y_d = cmd_q.y_neg ? y_q - 1'b1 : y_q + 1'b1;
          end
        end
      end
      S_RES: begin
        state_d = S_RES2;
      end
      S_RES2: begin
        if (!out_valid_q || pop) begin
          out_valid_d        = 1'b1;
          out_d.cell_level   = lvl_r;
          if (lvl_r >= cfg_i.occ_thr) begin
            out_d.cell_class = CLASS_OCCUPIED;
          end else if (lvl_r <= cfg_i.free_thr) begin
            out_d.cell_class = CLASS_FREE;
          end else begin
            out_d.cell_class = CLASS_UNKNOWN;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  ogru_ram #(
    .Width(LevelW),
    .Depth(Depth)
  ) u_grid (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign stat_o.pop      = pop_cmd;
  assign stat_o.clearing = (state_q == S_CLEAR);
  assign empty           = !out_valid_q;
  assign out_word_o      = out_q;

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    err_q <= err_d;
    cmd_q <= cmd_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== sv/occupancy_grid_ray_update.sv =====
// Steps: a read passes S_IDLE, S_RES and S_RES2; a trace does S_RD and S_WR per visited cell, then S_RES and S_RES2.
// The back end handles one item at a time, set by the single grid RAM port
// pair doing one read-modify-write per cell.
// Reset: config returns to defaults, then the grid is swept to zero one cell per
// cycle, all GRID_SIZE * GRID_SIZE cells, with full held high.
module occupancy_grid_ray_update #(
  parameter int GridSize = ogru_pkg::GridSizeDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  ogru_pkg::in_word_t                  in_word_i,
  output logic                                empty,
  input  logic                                pop,
  output ogru_pkg::out_word_t                 out_word_o,
  input  logic                                cfg_we_i,
  input  logic [ogru_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [ogru_pkg::CfgDataW-1:0]       cfg_data_i
);
  import ogru_pkg::*;

  cfg_t       cfg_q;
  back_stat_t stat;
  logic       cmd_valid;
  cmd_t       cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hit_step    <= 4'd3;
      cfg_q.miss_step   <= 4'd1;
      cfg_q.level_limit <= 5'd20;
      cfg_q.occ_thr     <= 6'sd4;
      cfg_q.free_thr    <= -6'sd2;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HIT_STEP:    cfg_q.hit_step    <= cfg_data_i[3:0];
        CFG_MISS_STEP:   cfg_q.miss_step   <= cfg_data_i[3:0];
        CFG_LEVEL_LIMIT: cfg_q.level_limit <= cfg_data_i[4:0];
        CFG_OCC_THR:     cfg_q.occ_thr     <= signed'(cfg_data_i);
        CFG_FREE_THR:    cfg_q.free_thr    <= signed'(cfg_data_i);
        default: ;
      endcase
    end
  end

  ogru_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_word_i  (in_word_i),
    .stat_i     (stat),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd)
  );

  ogru_back #(
    .GridSize(GridSize)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .empty      (empty),
    .pop        (pop),
    .out_word_o (out_word_o)
  );

endmodule

// ===== sv/ogru_checker.sv =====
// Port-level checker for the occupancy grid block and its bind.
`include "occupancy_grid_ray_update_defines.svh"

module ogru_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 push,
  input logic                 full,
  input logic                 empty,
  input logic                 pop,
  input ogru_pkg::out_word_t  out_word_o
);
  import ogru_pkg::*;

  logic [3:0] pend_q;
  logic       in_acc, out_acc;

  assign in_acc  = push && !full;
  assign out_acc = pop && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 4'd0;
    end else begin
      pend_q <= pend_q + {3'b0, in_acc} - {3'b0, out_acc};
    end
  end

  `OGRU_ASSERT_NOW(a_no_orphan, !empty, pend_q != 4'd0, "result word without accepted item")
  `OGRU_ASSERT_NOW(a_class_code, !empty, out_word_o.cell_class != 2'd3, "bad class code")
  `OGRU_ASSERT_NOW(a_level_range, !empty, out_word_o.cell_level != -6'sd32, "level out of range")
  `OGRU_ASSERT_NEXT(a_hold, !empty && !pop, $stable(out_word_o) && !empty, "result word changed")

endmodule

bind occupancy_grid_ray_update ogru_checker u_ogru_checker (.*);

// ===== verif/tb.sv =====
// Self-checking testbench for the occupancy grid ray update block.
`timescale 1ns / 1ps

module tb;
  import ogru_pkg::*;

  class grid_scoreboard;
    byte       levels[int];
    int        hit_step, miss_step, level_limit, occ_thr, free_thr;
    out_word_t expected_cells[$];
    int        errors;

    function new();
      hit_step    = 3;
      miss_step   = 1;
      level_limit = 20;
      occ_thr     = 4;
      free_thr    = -2;
      errors      = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_HIT_STEP: hit_step = data[3:0];
        CFG_MISS_STEP: miss_step = data[3:0];
        CFG_LEVEL_LIMIT: level_limit = data[4:0];
        CFG_OCC_THR: occ_thr = $signed(data);
        CFG_FREE_THR: free_thr = $signed(data);
        default: ;
      endcase
    endfunction

    function int level_at(int x, int y);
      int key;
      key = y * 1024 + x;
      return levels.exists(key) ? int'(levels[key]) : 0;
    endfunction

    function void bump_cell(int x, int y, int delta);
      int v;
      v = level_at(x, y) + delta;
      if (v > level_limit) v = level_limit;
      if (v < -level_limit) v = -level_limit;
      levels[y * 1024 + x] = byte'(v);
    endfunction

    function void walk_ray(int x0, int y0, int x1, int y1, bit obstacle);
      int dx, dy, sx, sy, err, twice;
      dx  = x1 > x0 ? x1 - x0 : x0 - x1;
      dy  = -(y1 > y0 ? y1 - y0 : y0 - y1);
      sx  = x0 < x1 ? 1 : -1;
      sy  = y0 < y1 ? 1 : -1;
      err = dx + dy;
      while (x0 != x1 || y0 != y1) begin
        twice = 2 * err;
        bump_cell(x0, y0, -miss_step);
        if (twice >= dy) begin
          err += dy;
          x0 += sx;
        end
        if (twice <= dx) begin
          err += dx;
          y0 += sy;
        end
      end
      bump_cell(x1, y1, obstacle ? hit_step : -miss_step);
    endfunction

    function void note_item(in_word_t w);
      out_word_t exp_w;
      int        lvl;
      if (w.operation == OP_TRACE)
        walk_ray(w.start_x, w.start_y, w.target_x, w.target_y, w.hit);
      lvl = level_at(w.target_x, w.target_y);
      exp_w.cell_level = lvl[LevelW-1:0];
      if (lvl >= occ_thr) exp_w.cell_class = CLASS_OCCUPIED;
      else if (lvl <= free_thr) exp_w.cell_class = CLASS_FREE;
      else exp_w.cell_class = CLASS_UNKNOWN;
      expected_cells.push_back(exp_w);
    endfunction

    task report(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
    endtask

    task check_word(out_word_t w);
      out_word_t exp_w;
      if (expected_cells.size() == 0) begin
        report("unexpected word", int'(w), 0);
        return;
      end
      exp_w = expected_cells.pop_front();
      if (w.cell_level !== exp_w.cell_level)
        report("cell_level", w.cell_level, exp_w.cell_level);
      if (w.cell_class !== exp_w.cell_class)
        report("cell_class", w.cell_class, exp_w.cell_class);
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                push;
  logic                full;
  in_word_t            in_word_i;
  logic                empty;
  logic                pop;
  out_word_t           out_word_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  grid_scoreboard sb = new();
  bit             idle_on = 1;
  bit             hold_req = 0;
  int             base_x, base_y;

  occupancy_grid_ray_update u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_word_i  (in_word_i),
    .empty      (empty),
    .pop        (pop),
    .out_word_o (out_word_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("simulation failed");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int held;
    pop = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        pop <= 0;
        for (held = 0; held < 400; held++) @(posedge clk_i);
        hold_req = 0;
      end
      pop <= !(idle_on && $urandom_range(99) < 26);
      @(negedge clk_i);
      if (pop && !empty) sb.check_word(out_word_o);
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, int data);
    @(posedge clk_i);
    cfg_we_i   <= 1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data[CfgDataW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.set_reg(idx, data[CfgDataW-1:0]);
  endtask

  task automatic drain();
    @(posedge clk_i);
    push <= 0;
    while (sb.expected_cells.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic send(in_word_t w);
    if (idle_on && $urandom_range(99) < 26) begin
      @(posedge clk_i);
      push <= 0;
      repeat ($urandom_range(4)) @(posedge clk_i);
    end
    @(posedge clk_i);
    push      <= 1;
    in_word_i <= w;
    forever begin
      @(negedge clk_i);
      if (!full) break;
    end
    sb.note_item(w);
  endtask

  task automatic send_fields(bit op, int sx, int sy, int tx, int ty, bit obstacle);
    in_word_t w;
    w.operation = op;
    w.start_x   = CoordW'(sx);
    w.start_y   = CoordW'(sy);
    w.target_x  = CoordW'(tx);
    w.target_y  = CoordW'(ty);
    w.hit       = obstacle;
    send(w);
  endtask

  task automatic send_random();
    in_word_t w;
    w = ($bits(in_word_t))'({$urandom, $urandom});
    if ($urandom_range(99) < 5) begin
      send(w);
      return;
    end
    w.operation = $urandom_range(99) < 30 ? OP_READ : OP_TRACE;
    w.start_x   = CoordW'(base_x + $urandom_range(15));
    w.start_y   = CoordW'(base_y + $urandom_range(15));
    w.target_x  = CoordW'(base_x + $urandom_range(15));
    w.target_y  = CoordW'(base_y + $urandom_range(15));
    if ($urandom_range(9) == 0) begin
      w.start_x = w.target_x;
      w.start_y = w.target_y;
    end
    send(w);
  endtask

  task automatic random_config();
    write_reg(CFG_HIT_STEP, $urandom_range(3) == 0 ? 15 : $urandom_range(15));
    write_reg(CFG_MISS_STEP, $urandom_range(3) == 0 ? 0 : $urandom_range(15));
    write_reg(CFG_LEVEL_LIMIT, $urandom_range(3) == 0 ? 31 : $urandom_range(31));
    write_reg(CFG_OCC_THR, $urandom_range(63));
    write_reg(CFG_FREE_THR, $urandom_range(63));
  endtask

  initial begin
    int phase, n;
    rst_ni     = 0;
    push       = 0;
    in_word_i  = '0;
    cfg_we_i   = 0;
    cfg_idx_i  = CFG_HIT_STEP;
    cfg_data_i = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);
    while (full) @(negedge clk_i);

    // defaults: corners, long diagonals, start equal to end
    send_fields(OP_READ, 0, 0, 0, 0, 0);
    send_fields(OP_READ, 1023, 1023, 1023, 1023, 1);
    send_fields(OP_TRACE, 5, 5, 5, 5, 1);
    send_fields(OP_TRACE, 0, 0, 1023, 1023, 1);
    send_fields(OP_TRACE, 1023, 0, 0, 1023, 0);
    send_fields(OP_TRACE, 0, 512, 1023, 512, 1);
    send_fields(OP_TRACE, 300, 1023, 300, 0, 0);
    send_fields(OP_READ, 0, 0, 511, 511, 0);
    send_fields(OP_READ, 0, 0, 300, 512, 0);
    drain();

    // extremes: saturate at the top limit, then lower it
    write_reg(CFG_HIT_STEP, 15);
    write_reg(CFG_MISS_STEP, 0);
    write_reg(CFG_LEVEL_LIMIT, 31);
    write_reg(CFG_OCC_THR, 31);
    write_reg(CFG_FREE_THR, -32);
    repeat (3) send_fields(OP_TRACE, 10, 10, 12, 11, 1);
    drain();
    write_reg(CFG_LEVEL_LIMIT, 2);
    write_reg(CFG_OCC_THR, -5);
    write_reg(CFG_FREE_THR, 5);
    send_fields(OP_READ, 0, 0, 12, 11, 0);
    send_fields(OP_TRACE, 12, 11, 12, 11, 0);
    drain();
    write_reg(CFG_LEVEL_LIMIT, 0);
    write_reg(CFG_MISS_STEP, 15);
    write_reg(CFG_FREE_THR, -31);
    send_fields(OP_TRACE, 8, 8, 12, 11, 1);
    send_fields(OP_READ, 0, 0, 8, 8, 0);
    drain();

    for (phase = 0; phase < 5; phase++) begin
      random_config();
      idle_on = (phase != 2);
      for (n = 0; n < 112; n++) begin
        if (n % 16 == 0) begin
          base_x = $urandom_range(1008);
          base_y = $urandom_range(1008);
        end
        if (phase == 3 && n == 20) hold_req = 1;
        send_random();
      end
      drain();
    end
    idle_on = 1;

    repeat (50) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_cells.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
